// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl files
// every property samples on clk and is off while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SKF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg
// shared constants, register codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package skf_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_W        = GAIN_BITS + 1;
  localparam int DATA_W        = 32;
  localparam int SAMPLE_W      = 16;
  localparam int MEAS_W        = SAMPLE_W + FRACTION_BITS;
  localparam int DIFF_W        = ((MEAS_W > DATA_W) ? MEAS_W : DATA_W) + 1;
  localparam int PROD_W        = GAIN_W + 1 + DIFF_W;
  localparam int UPD_W         = DIFF_W + 2;
  localparam int DIV_STEPS     = GAIN_BITS + 1;
  localparam int CNT_W         = $clog2(DIV_STEPS);
  localparam int IDX_W         = 2;
  localparam int TDATA_W       = ((2 * DATA_W + GAIN_W + 7) / 8) * 8;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

  // register indexes
  localparam logic [IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
  localparam logic [IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
  localparam logic [IDX_W-1:0] REG_INITIAL_ESTIMATE  = 2'd2;
  localparam logic [IDX_W-1:0] REG_INITIAL_VARIANCE  = 2'd3;

  // register reset values
  localparam logic [DATA_W-1:0] RST_PROCESS_NOISE     = 32'd655;
  localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE = 32'd65536;
  localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE  = 32'd0;
  localparam logic [DATA_W-1:0] RST_INITIAL_VARIANCE  = 32'd65536;

  typedef struct packed {
    logic load;        // latch the sample on input transfer
    logic predict;     // predicted variance, denominator, residual
    logic div_step;    // one restoring divider step
    logic mul_est;     // gain times residual into product register
    logic mul_var;     // estimate update, (one - gain) times variance
    logic write_back;  // variance update and output register load
  } skf_cmd_t;

  typedef struct packed {
    logic div_last;    // divider is on its final step
  } skf_status_t;

endpackage

// ----- src/skf_datapath.sv -----
// ----------------------------------------------------------------------------
// skf_datapath
// config registers, filter state, serial gain divider and shared multiplier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_datapath import skf_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [IDX_W-1:0]           cfg_index,
  input  logic [DATA_W-1:0]          cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  input  skf_cmd_t                   cmd,
  output skf_status_t                status,
  output logic signed [DATA_W-1:0]   filtered_estimate,
  output logic [DATA_W-1:0]          error_variance,
  output logic [GAIN_W-1:0]          kalman_gain
);

  logic [DATA_W-1:0]          process_noise;
  logic [DATA_W-1:0]          measurement_noise;
  logic [DATA_W-1:0]          initial_estimate;
  logic [DATA_W-1:0]          initial_variance;
  logic signed [DATA_W-1:0]   estimate;
  logic [DATA_W-1:0]          variance;
  logic signed [SAMPLE_W-1:0] sample;
  logic [DATA_W-1:0]          pm;
  logic [DATA_W:0]            sum;
  logic                       sum_zero;
  logic [DATA_W:0]            rem;
  logic [GAIN_W-1:0]          quo;
  logic [CNT_W-1:0]           cnt;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;

  logic [DATA_W:0]            pm_wide;
  logic [DATA_W-1:0]          pm_next;
  logic [DATA_W:0]            sum_next;
  logic signed [MEAS_W-1:0]   meas;
  logic signed [DIFF_W-1:0]   diff_next;
  logic                       shift_bit;
  logic [DATA_W+1:0]          trial;
  logic [DATA_W+1:0]          trial_sub;
  logic                       q_bit;
  logic [GAIN_W-1:0]          gain;
  logic [GAIN_W-1:0]          mul_a;
  logic signed [GAIN_W:0]     mul_a_s;
  logic signed [DIFF_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   product;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [UPD_W-1:0]    upd;
  logic                       upd_fits;
  logic signed [DATA_W-1:0]   est_next;
  logic [DATA_W-1:0]          var_new;

  // prediction: saturating variance plus process noise
  assign pm_wide   = {1'b0, variance} + {1'b0, process_noise};
  assign pm_next   = pm_wide[DATA_W] ? '1 : pm_wide[DATA_W-1:0];
  assign sum_next  = {1'b0, pm_next} + {1'b0, measurement_noise};
  assign meas      = {sample, {FRACTION_BITS{1'b0}}};
  assign diff_next = DIFF_W'(meas) - DIFF_W'(estimate);

  // restoring divider on (pm << GAIN_BITS) / sum, upper quotient bits known zero
  assign shift_bit = (cnt == '0) ? pm[0] : 1'b0;
  assign trial     = {rem, shift_bit};
  assign trial_sub = trial - {1'b0, sum};
  assign q_bit     = ~trial_sub[DATA_W+1];
  assign gain      = sum_zero ? '0 : quo;

  // shared multiplier
  assign mul_a   = cmd.mul_est ? gain : GAIN_ONE - gain;
  assign mul_a_s = $signed({1'b0, mul_a});
  assign mul_b   = cmd.mul_est ? diff : $signed({{(DIFF_W-DATA_W){1'b0}}, pm});
  assign product = mul_a_s * mul_b;

  // estimate update with floor shift and saturation
  assign shifted  = prod >>> GAIN_BITS;
  assign upd      = $signed(shifted[UPD_W-1:0]) + UPD_W'(estimate);
  assign upd_fits = (&upd[UPD_W-1:DATA_W-1]) | ~(|upd[UPD_W-1:DATA_W-1]);
  assign est_next = upd_fits ? upd[DATA_W-1:0] :
                    upd[UPD_W-1] ? $signed({1'b1, {(DATA_W-1){1'b0}}}) :
                                   $signed({1'b0, {(DATA_W-1){1'b1}}});

  assign var_new = prod[GAIN_BITS +: DATA_W];

  assign status.div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise     <= RST_PROCESS_NOISE;
      measurement_noise <= RST_MEASUREMENT_NOISE;
      initial_estimate  <= RST_INITIAL_ESTIMATE;
      initial_variance  <= RST_INITIAL_VARIANCE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE:     process_noise     <= cfg_data;
        REG_MEASUREMENT_NOISE: measurement_noise <= cfg_data;
        REG_INITIAL_ESTIMATE:  initial_estimate  <= cfg_data;
        REG_INITIAL_VARIANCE:  initial_variance  <= cfg_data;
        default: ;
      endcase
    end
  end

  // filter state, reloaded on any register write
  always_ff @(posedge clk) begin
    if (rst) begin
      estimate <= $signed(RST_INITIAL_ESTIMATE);
      variance <= RST_INITIAL_VARIANCE;
    end else if (cfg_we) begin
      estimate <= (cfg_index == REG_INITIAL_ESTIMATE) ? $signed(cfg_data)
                                                       : $signed(initial_estimate);
      variance <= (cfg_index == REG_INITIAL_VARIANCE) ? cfg_data : initial_variance;
    end else begin
      if (cmd.mul_var) begin
        estimate <= est_next;
      end
      if (cmd.write_back) begin
        variance <= var_new;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= sample_value;
    end
    if (cmd.predict) begin
      pm       <= pm_next;
      sum      <= sum_next;
      sum_zero <= (sum_next == '0);
      rem      <= {2'b00, pm_next[DATA_W-1:1]};
      quo      <= '0;
      cnt      <= '0;
      diff     <= diff_next;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? trial_sub[DATA_W:0] : trial[DATA_W:0];
      quo <= {quo[GAIN_W-2:0], q_bit};
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.mul_est || cmd.mul_var) begin
      prod <= product;
    end
    if (cmd.write_back) begin
      filtered_estimate <= estimate;
      error_variance    <= var_new;
      kalman_gain       <= gain;
    end
  end

  `SKF_ASSERT_SAME(a_gain_range, cmd.write_back, gain <= GAIN_ONE, "gain above one")
  `SKF_ASSERT_SAME(a_var_shrinks, cmd.write_back, var_new <= pm, "variance above prediction")

endmodule

// ----- src/skf_ctrl.sv -----
// ----------------------------------------------------------------------------
// skf_ctrl
// sequencer for one filter step and output valid tracking
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module skf_ctrl import skf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  skf_status_t status,
  output skf_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PRED = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MULE = 3'd3;
  localparam logic [2:0] ST_MULV = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PRED;
        end
      end
      ST_PRED: begin
        cmd.predict = 1'b1;
        state_next  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_MULE;
        end
      end
      ST_MULE: begin
        cmd.mul_est = 1'b1;
        state_next  = ST_MULV;
      end
      ST_MULV: begin
        cmd.mul_var = 1'b1;
        state_next  = ST_WB;
      end
      ST_WB: begin
        if (out_free) begin
          cmd.write_back = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.write_back) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `SKF_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state == ST_PRED, "accept without start")
  `SKF_ASSERT_NEXT(a_div_ends, state == ST_DIV && status.div_last, state == ST_MULE, "divider overrun")
  `SKF_ASSERT_NEXT(a_wb_shows, state == ST_WB && !out_valid, out_valid, "result not presented")

endmodule

// ----- src/scalar_kalman_filter.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter: one-dimensional fixed-point kalman filter
// steps: load, predict, 17-step gain divider, two multiplier passes, write back
// one sample in flight; write back waits for a free output register
// reset: synchronous, loads default registers, estimate 0, variance 1.0
// ----------------------------------------------------------------------------
module scalar_kalman_filter import skf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  // sample stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_value
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata    // filtered_estimate, error_variance,
                                               // kalman_gain, zero pad
);

  skf_cmd_t                 cmd;
  skf_status_t              status;
  logic signed [DATA_W-1:0] filtered_estimate;
  logic [DATA_W-1:0]        error_variance;
  logic [GAIN_W-1:0]        kalman_gain;

  // sequencer: one item in flight; the output register lets a new
  // sample transfer while the previous result still waits downstream
  skf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: predict, divide for the gain, then two passes through
  // the shared multiplier for the estimate and the variance
  skf_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .sample_value      ($signed(s_axis_tdata)),
    .cmd               (cmd),
    .status            (status),
    .filtered_estimate (filtered_estimate),
    .error_variance    (error_variance),
    .kalman_gain       (kalman_gain)
  );

  // result packing, first field in the low bits
  assign m_axis_tdata = {{(TDATA_W - 2 * DATA_W - GAIN_W){1'b0}},
                         kalman_gain, error_variance, filtered_estimate};

endmodule
